@@ design/dtpb_pkg.sv @@
// Shared types, constants and helper functions for the depth-to-point back-projector.
package dtpb_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int MAX_HEIGHT      = 4096;
   localparam int DEPTH_FRAC_BITS = 16;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int CNT_W   = 25;
   localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(16777216);

   localparam int POS_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 4;
   localparam int D_W     = ((POS_W > 16) ? POS_W : 16) + 1;
   localparam int MAG_D_W = D_W - 1;
   localparam int T_W     = MAG_D_W + 24;
   localparam int PL_W    = T_W + 16;
   localparam int ACC_W   = T_W + 32;
   localparam int LAT_SHIFT = DEPTH_FRAC_BITS + 12;
   localparam int LAT_W   = ACC_W - LAT_SHIFT;

   localparam int FWD_SHR = (DEPTH_FRAC_BITS >= 16) ? DEPTH_FRAC_BITS - 16 : 0;
   localparam int FWD_SHL = (DEPTH_FRAC_BITS >= 16) ? 0 : 16 - DEPTH_FRAC_BITS;

   localparam int DIV_RECIP_W = 29;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 29'h10624DD3;
   localparam int DIV_SHIFT   = 38;
   localparam int DIV_PROD_W  = 32 + DIV_RECIP_W;

   localparam logic [31:0] SAT_POS = 32'h7FFFFFFF;
   localparam logic [31:0] SAT_NEG = 32'h80000000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_COL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEPTH     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MM_THRESHOLD  = 3'd7;

   localparam logic [15:0] RST_CENTER_COL    = 16'd5120;
   localparam logic [15:0] RST_CENTER_ROW    = 16'd3840;
   localparam logic [23:0] RST_INV_FOCAL     = 24'd27962;
   localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
   localparam logic [31:0] RST_MIN_DEPTH     = 32'd6554;
   localparam logic [31:0] RST_MAX_DEPTH     = 32'd3276800;
   localparam logic [31:0] RST_MM_THRESHOLD  = 32'd6553600;

   typedef struct packed {
      logic [15:0] center_col;
      logic [15:0] center_row;
      logic [23:0] inv_focal_col;
      logic [23:0] inv_focal_row;
      logic [12:0] image_width;
      logic [31:0] min_depth;
      logic [31:0] max_depth;
      logic [31:0] mm_threshold;
   } cfg_type;

   typedef struct packed {
      logic [31:0] depth;
      logic        depth_not_finite;
      logic        frame_start;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_forward;
      logic signed [31:0] pos_left;
      logic signed [31:0] pos_up;
      logic               point_valid;
      logic               end_of_frame;
      logic [CNT_W-1:0]   point_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       z;
      logic [D_W-1:0]    du;
      logic [D_W-1:0]    dv;
      logic              kept;
      logic              eof;
      logic [CNT_W-1:0]  count;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      full;
      logic      empty;
   } queue_ctl_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SCALE,
      FR_CLASSIFY
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_T,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_ACC,
      BK_SAT,
      BK_EMIT
   } back_state_type;

   function automatic logic [31:0] forward_coord(input logic [31:0] z);
      logic [63:0] f;
      f = 64'(z);
      f = (f >> FWD_SHR) << FWD_SHL;
      return (f > 64'(SAT_POS)) ? SAT_POS : f[31:0];
   endfunction

endpackage

@@ design/dtpb_front.sv @@
// Front end: accepts pixels, tracks raster position and count, scales and classifies depth.
module dtpb_front (
   input  logic                clock,
   input  logic                reset,
   input  dtpb_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  dtpb_pkg::req_type   req_data,
   output logic                q_push,
   output dtpb_pkg::entry_type q_wdata,
   input  logic                q_full
);
   import dtpb_pkg::*;

   front_state_type state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] raw_ff;
   logic nf_ff, end_ff;
   logic [D_W-1:0] du_ff, dv_ff;
   logic [DIV_PROD_W-1:0] prod_ff;

   logic accept;
   logic [COL_W-1:0] col_eff;
   logic [ROW_W-1:0] row_eff;
   logic [COL_W:0] next_col;
   logic [ROW_W:0] next_row;
   logic col_wrap;
   logic [D_W-1:0] du_new, dv_new;
   logic [31:0] z_scaled, z;
   logic kept, emit, done;
   logic [CNT_W-1:0] cnt_inc, cnt_new;

   assign accept   = req_valid && (state_ff == FR_IDLE);
   assign col_eff  = req_data.frame_start ? '0 : col_ff;
   assign row_eff  = req_data.frame_start ? '0 : row_ff;
   assign next_col = (COL_W+1)'(col_eff) + 1'b1;
   assign next_row = (ROW_W+1)'(row_eff) + 1'b1;
   assign col_wrap = (32'(next_col) >= 32'(cfg.image_width)) ||
                     (32'(next_col) >= 32'(MAX_WIDTH));
   assign du_new   = (D_W'(col_eff) << 4) - D_W'(cfg.center_col);
   assign dv_new   = (D_W'(row_eff) << 4) - D_W'(cfg.center_row);

   assign z_scaled = 32'(prod_ff >> DIV_SHIFT);
   assign z        = (raw_ff > cfg.mm_threshold) ? z_scaled : raw_ff;
   assign kept     = !nf_ff && (z > cfg.min_depth) && (z < cfg.max_depth);
   assign emit     = kept || end_ff;
   assign done     = !emit || !q_full;
   assign cnt_inc  = (cnt_ff < COUNT_CAP) ? cnt_ff + 1'b1 : cnt_ff;
   assign cnt_new  = kept ? cnt_inc : cnt_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               state_in = FR_SCALE;
            end
         end
         FR_SCALE: begin
            state_in = FR_CLASSIFY;
         end
         FR_CLASSIFY: begin
            if (done) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = (state_ff != FR_IDLE);
      q_push    = (state_ff == FR_CLASSIFY) && emit && !q_full;
      q_wdata.z     = z;
      q_wdata.du    = du_ff;
      q_wdata.dv    = dv_ff;
      q_wdata.kept  = kept;
      q_wdata.eof   = end_ff;
      q_wdata.count = cnt_new;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = (32'(next_row) >= 32'(MAX_HEIGHT)) ? '0 : next_row[ROW_W-1:0];
         end else begin
            col_in = next_col[COL_W-1:0];
            row_in = row_eff;
         end
         if (req_data.frame_start) begin
            cnt_in = '0;
         end
      end else if ((state_ff == FR_CLASSIFY) && done) begin
         if (end_ff) begin
            col_in = '0;
            row_in = '0;
            cnt_in = '0;
         end else begin
            cnt_in = cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff <= req_data.depth;
         nf_ff  <= req_data.depth_not_finite;
         end_ff <= req_data.frame_end;
         du_ff  <= du_new;
         dv_ff  <= dv_new;
      end
      if (state_ff == FR_SCALE) begin
         prod_ff <= DIV_PROD_W'(raw_ff) * DIV_PROD_W'(DIV_RECIP);
      end
   end

endmodule

@@ design/dtpb_queue.sv @@
// Short first-in first-out queue between the front end and the back end.
module dtpb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dtpb_pkg::entry_type wdata,
   input  logic                pop,
   output dtpb_pkg::entry_type rdata,
   output logic                full,
   output logic                empty
);
   import dtpb_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full    = (32'(cnt_ff) == QUEUE_DEPTH);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) + 1 == QUEUE_DEPTH) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) + 1 == QUEUE_DEPTH) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ design/dtpb_back.sv @@
// Back end: back-projects a kept point through sequential multiply steps and drives the result register.
module dtpb_back (
   input  logic                clock,
   input  logic                reset,
   input  dtpb_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  dtpb_pkg::entry_type q_rdata,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dtpb_pkg::rsp_type   rsp_data
);
   import dtpb_pkg::*;

   back_state_type state_ff, state_in;
   entry_type cur_ff;
   logic axis_ff, axis_in;
   logic [T_W-1:0] t_ff;
   logic [PL_W-1:0] prod_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [31:0] left_ff, up_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic [D_W-1:0] d;
   logic d_neg, d_pos;
   logic [MAG_D_W-1:0] mag_d;
   logic [23:0] invf;
   logic [LAT_W-1:0] mag_l;
   logic big;
   logic [31:0] lat;
   logic out_free, load;
   rsp_type rsp_new;

   assign d     = axis_ff ? cur_ff.dv : cur_ff.du;
   assign d_neg = d[D_W-1];
   assign d_pos = !d_neg && (d != '0);
   assign mag_d = d_neg ? MAG_D_W'(-d) : d[MAG_D_W-1:0];
   assign invf  = axis_ff ? cfg.inv_focal_row : cfg.inv_focal_col;
   assign mag_l = acc_ff[ACC_W-1:LAT_SHIFT];
   assign big   = (mag_l >> 31) != '0;

   always_comb begin
      if (d_pos) begin
         lat = big ? SAT_NEG : 32'd0 - mag_l[31:0];
      end else begin
         lat = big ? SAT_POS : mag_l[31:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               axis_in  = 1'b0;
               state_in = q_rdata.kept ? BK_MUL_T : BK_EMIT;
            end
         end
         BK_MUL_T: begin
            state_in = BK_MUL_LO;
         end
         BK_MUL_LO: begin
            state_in = BK_MUL_HI;
         end
         BK_MUL_HI: begin
            state_in = BK_ACC;
         end
         BK_ACC: begin
            state_in = BK_SAT;
         end
         BK_SAT: begin
            if (axis_ff) begin
               state_in = BK_EMIT;
            end else begin
               axis_in  = 1'b1;
               state_in = BK_MUL_T;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop = (state_ff == BK_IDLE) && !q_empty;
      load  = (state_ff == BK_EMIT) && out_free;
      if (cur_ff.kept) begin
         rsp_new.pos_forward = forward_coord(cur_ff.z);
         rsp_new.pos_left    = left_ff;
         rsp_new.pos_up      = up_ff;
         rsp_new.point_valid = 1'b1;
      end else begin
         rsp_new.pos_forward = '0;
         rsp_new.pos_left    = '0;
         rsp_new.pos_up      = '0;
         rsp_new.point_valid = 1'b0;
      end
      rsp_new.end_of_frame = cur_ff.eof;
      rsp_new.point_count  = cur_ff.count;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_rdata;
      end
      if (state_ff == BK_MUL_T) begin
         t_ff <= T_W'(mag_d) * T_W'(invf);
      end
      if (state_ff == BK_MUL_LO) begin
         acc_ff <= ACC_W'(PL_W'(t_ff) * PL_W'(cur_ff.z[15:0]));
      end
      if (state_ff == BK_MUL_HI) begin
         prod_ff <= PL_W'(t_ff) * PL_W'(cur_ff.z[31:16]);
      end
      if (state_ff == BK_ACC) begin
         acc_ff <= acc_ff + (ACC_W'(prod_ff) << 16);
      end
      if (state_ff == BK_SAT) begin
         if (axis_ff) begin
            up_ff <= lat;
         end else begin
            left_ff <= lat;
         end
      end
      if (load) begin
         rsp_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/depth_to_point_backprojector_top.sv @@
// Top level of the depth-to-point back-projector: configuration registers and the two halves.
//
// Depth pixels enter in raster order on the req_ channel (valid/stall); a transaction is
// taken when req_valid is high and req_stall is low. Each result transaction on the rsp_
// channel carries one kept point, or the end-of-frame marker for the frame's last pixel.
// Configuration is written through csr_we, csr_index and csr_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. The front end accepts a pixel,
// does the reciprocal multiply of the millimetre scaling, then classifies the pixel and queues it
// if it is kept or ends the frame; it takes no new pixel until then and waits while the queue is
// full. A kept point then passes through the back end, which runs both lateral products through
// sequential multiply steps (5 steps per axis) before loading the output register; an end-of-frame
// marker for a dropped pixel goes straight to the output register. The back end therefore sets the
// sustained rate for kept points. A two-entry queue between the halves lets the front keep
// accepting while a result waits. When the receiver holds rsp_stall, the result register keeps
// its transaction, the back end waits, the queue fills and req_stall follows. Synchronous reset
// clears the counters, the queue and the output valid, and returns the configuration registers
// to their defaults.
module depth_to_point_backprojector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dtpb_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dtpb_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [dtpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);
   import dtpb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   entry_type q_wdata, q_rdata;
   logic q_push, q_pop, q_full, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_COL:    cfg_in.center_col    = csr_wdata[15:0];
            CSR_CENTER_ROW:    cfg_in.center_row    = csr_wdata[15:0];
            CSR_INV_FOCAL_COL: cfg_in.inv_focal_col = csr_wdata[23:0];
            CSR_INV_FOCAL_ROW: cfg_in.inv_focal_row = csr_wdata[23:0];
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_wdata[12:0];
            CSR_MIN_DEPTH:     cfg_in.min_depth     = csr_wdata;
            CSR_MAX_DEPTH:     cfg_in.max_depth     = csr_wdata;
            CSR_MM_THRESHOLD:  cfg_in.mm_threshold  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_col    <= RST_CENTER_COL;
         cfg_ff.center_row    <= RST_CENTER_ROW;
         cfg_ff.inv_focal_col <= RST_INV_FOCAL;
         cfg_ff.inv_focal_row <= RST_INV_FOCAL;
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.min_depth     <= RST_MIN_DEPTH;
         cfg_ff.max_depth     <= RST_MAX_DEPTH;
         cfg_ff.mm_threshold  <= RST_MM_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtpb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_wdata   (q_wdata),
      .q_full    (q_full)
   );

   dtpb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   dtpb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
